### rtl/fmrc_pkg.sv
// ----------------------------------------------------------------------------
// fmrc_pkg
// Types and constants shared by the rule classifier chain.
// ----------------------------------------------------------------------------
package fmrc_pkg;

   localparam int IDX_W   = 6;
   localparam int ADDR_W  = 32;
   localparam int PORTS_W = 32;
   localparam int PORT_W  = 16;
   localparam int PROTO_W = 8;

   typedef enum logic [1:0] {
      CMD_CLASSIFY   = 2'd0,
      CMD_WRITE      = 2'd1,
      CMD_INVALIDATE = 2'd2,
      CMD_CLEAR      = 2'd3
   } cmd_type;

   typedef struct packed {
      logic               vld;
      cmd_type            cmd;
      logic [IDX_W-1:0]   index;
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  src_mask;
      logic [ADDR_W-1:0]  dst_addr;
      logic [ADDR_W-1:0]  dst_mask;
      logic [PORTS_W-1:0] src_ports;
      logic [PORTS_W-1:0] dst_ports;
      logic [PROTO_W-1:0] protocol;
      logic               rule_accept;
      logic               rule_log;
      logic               found;
      logic [IDX_W-1:0]   hit_index;
      logic               hit_accept;
      logic               hit_log;
   } beat_type;

   function automatic logic port_in_range(input logic [PORTS_W-1:0] ports,
                                          input logic [PORTS_W-1:0] range);
      logic [PORT_W-1:0] p;
      p = ports[PORT_W-1:0];
      return (p >= range[PORTS_W-1:PORT_W]) && (p <= range[PORT_W-1:0]);
   endfunction

endpackage

### rtl/fmrc_cell.sv
// ----------------------------------------------------------------------------
// fmrc_cell
// One rule slot: holds the rule, matches the passing beat, updates itself.
// ----------------------------------------------------------------------------
module fmrc_cell #(
   parameter int CELL_ID = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fmrc_pkg::beat_type beat_in,
   output fmrc_pkg::beat_type beat_out
);

   logic                             valid_ff;
   logic [fmrc_pkg::ADDR_W-1:0]      sa_ff, sm_ff, da_ff, dm_ff;
   logic [fmrc_pkg::PORTS_W-1:0]     sr_ff, dr_ff;
   logic [fmrc_pkg::PROTO_W-1:0]     proto_ff;
   logic                             acc_ff, log_ff;
   fmrc_pkg::beat_type               beat_ff, beat_in_nxt;
   logic                             hit, sel;

   assign sel = (32'(beat_in.index) == CELL_ID);

   always_comb begin
      hit = valid_ff
         && ((beat_in.src_addr & sm_ff) == (sa_ff & sm_ff))
         && ((beat_in.dst_addr & dm_ff) == (da_ff & dm_ff))
         && fmrc_pkg::port_in_range(beat_in.src_ports, sr_ff)
         && fmrc_pkg::port_in_range(beat_in.dst_ports, dr_ff)
         && ((proto_ff == '0) || (proto_ff == beat_in.protocol));
      beat_in_nxt = beat_in;
      if (beat_in.cmd == fmrc_pkg::CMD_CLASSIFY && !beat_in.found && hit) begin
         beat_in_nxt.found      = 1'b1;
         beat_in_nxt.hit_index  = fmrc_pkg::IDX_W'(CELL_ID);
         beat_in_nxt.hit_accept = acc_ff;
         beat_in_nxt.hit_log    = log_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         beat_ff.vld <= 1'b0;
      end else if (advance) begin
         beat_ff <= beat_in_nxt;
         if (beat_in.vld) begin
            case (beat_in.cmd)
               fmrc_pkg::CMD_WRITE: begin
                  if (sel) begin
                     valid_ff <= 1'b1;
                     sa_ff    <= beat_in.src_addr;
                     sm_ff    <= beat_in.src_mask;
                     da_ff    <= beat_in.dst_addr;
                     dm_ff    <= beat_in.dst_mask;
                     sr_ff    <= beat_in.src_ports;
                     dr_ff    <= beat_in.dst_ports;
                     proto_ff <= beat_in.protocol;
                     acc_ff   <= beat_in.rule_accept;
                     log_ff   <= beat_in.rule_log;
                  end
               end
               fmrc_pkg::CMD_INVALIDATE: begin
                  if (sel) valid_ff <= 1'b0;
               end
               fmrc_pkg::CMD_CLEAR: valid_ff <= 1'b0;
               default: ;
            endcase
         end
      end
   end

   assign beat_out = beat_ff;

endmodule

### rtl/first_match_packet_rule_classifier.sv
// ----------------------------------------------------------------------------
// first_match_packet_rule_classifier
// Ordered first-match five-tuple rule table built as a chain of rule cells.
// ----------------------------------------------------------------------------
// Every beat (classify, write, invalidate or clear) walks the chain of
// RULE_COUNT cells, one cell per cycle while the chain advances; a new beat
// is taken every cycle while the response side does not stall. Beats stay
// in order, so table updates take effect for every later classify. Each
// beat gives one response.
module first_match_packet_rule_classifier #(
   parameter int RULE_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_index,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_src_mask,
   input  logic [31:0] req_dst_addr,
   input  logic [31:0] req_dst_mask,
   input  logic [31:0] req_src_ports,
   input  logic [31:0] req_dst_ports,
   input  logic [7:0]  req_protocol,
   input  logic        req_rule_accept,
   input  logic        req_rule_log,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   output logic [5:0]  rsp_hit_index,
   output logic        rsp_verdict_accept,
   output logic        rsp_verdict_log
);

   fmrc_pkg::beat_type chain [RULE_COUNT+1];
   logic               advance;

   assign advance   = !(chain[RULE_COUNT].vld && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      chain[0].vld         = req_valid;
      chain[0].cmd         = fmrc_pkg::cmd_type'(req_cmd);
      chain[0].index       = req_index;
      chain[0].src_addr    = req_src_addr;
      chain[0].src_mask    = req_src_mask;
      chain[0].dst_addr    = req_dst_addr;
      chain[0].dst_mask    = req_dst_mask;
      chain[0].src_ports   = req_src_ports;
      chain[0].dst_ports   = req_dst_ports;
      chain[0].protocol    = req_protocol;
      chain[0].rule_accept = req_rule_accept;
      chain[0].rule_log    = req_rule_log;
      chain[0].found       = 1'b0;
      chain[0].hit_index   = '0;
      chain[0].hit_accept  = 1'b0;
      chain[0].hit_log     = 1'b0;
   end

   for (genvar k = 0; k < RULE_COUNT; k++) begin : g_cell
      fmrc_cell #(.CELL_ID(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .beat_in  (chain[k]),
         .beat_out (chain[k+1])
      );
   end

   assign rsp_valid          = chain[RULE_COUNT].vld;
   assign rsp_matched        = chain[RULE_COUNT].found;
   assign rsp_hit_index      = chain[RULE_COUNT].hit_index;
   assign rsp_verdict_accept = chain[RULE_COUNT].hit_accept;
   assign rsp_verdict_log    = chain[RULE_COUNT].hit_log;

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> (rsp_hit_index == '0 && !rsp_verdict_accept
                                       && !rsp_verdict_log))
      else $error("unmatched response carries rule data");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> (32'(rsp_hit_index) < RULE_COUNT))
      else $error("hit index beyond table");

   a_match_classify: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> (chain[RULE_COUNT].cmd == fmrc_pkg::CMD_CLASSIFY))
      else $error("match on a table maintenance beat");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Rule table classifier check: table writes, invalidates, clears and
// classifies are driven through the request port, each response is compared
// with a first-match lookup kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int RULES     = 64;
   localparam int MAX_CYC   = 400000;
   localparam int SETTLE    = 3 * RULES;

   typedef struct {
      fmrc_pkg::cmd_type cmd;
      logic [5:0]  index;
      logic [31:0] src_addr, src_mask, dst_addr, dst_mask, src_ports, dst_ports;
      logic [7:0]  protocol;
      logic        accept, log_flag;
   } req_beat;

   typedef struct {
      logic       matched;
      logic [5:0] hit;
      logic       accept, log_flag;
   } rsp_beat;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0]  req_cmd;
   logic [5:0]  req_index;
   logic [31:0] req_src_addr, req_src_mask, req_dst_addr, req_dst_mask;
   logic [31:0] req_src_ports, req_dst_ports;
   logic [7:0]  req_protocol;
   logic req_rule_accept, req_rule_log;
   logic rsp_valid, rsp_stall, rsp_matched, rsp_verdict_accept, rsp_verdict_log;
   logic [5:0] rsp_hit_index;

   first_match_packet_rule_classifier #(.RULE_COUNT(RULES)) u_dut (.*);

   // shadow rule table
   logic        tbl_valid [RULES];
   logic [31:0] tbl_sa [RULES], tbl_sm [RULES], tbl_da [RULES], tbl_dm [RULES];
   logic [31:0] tbl_sr [RULES], tbl_dr [RULES];
   logic [7:0]  tbl_pr [RULES];
   logic        tbl_acc [RULES], tbl_log [RULES];

   req_beat pending_reqs[$];
   rsp_beat expected_verdicts[$];
   req_beat b_drv;
   logic    req_held;
   int  fail_cnt = 0;
   int  cycle_cnt = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   int  hold_off = 0;
   bit  gen_done = 0;
   int  tb_pct [5][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{33, 33}, '{0, 0}};

   initial clock = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic logic in_span(logic [31:0] port, logic [31:0] span);
      return port[15:0] >= span[31:16] && port[15:0] <= span[15:0];
   endfunction

   function automatic rsp_beat lookup_verdict(req_beat b);
      rsp_beat r;
      r = '{default: '0};
      case (b.cmd)
         fmrc_pkg::CMD_CLASSIFY: begin
            for (int k = 0; k < RULES; k++) begin
               if (tbl_valid[k] && ((b.src_addr & tbl_sm[k]) == (tbl_sa[k] & tbl_sm[k]))
                   && ((b.dst_addr & tbl_dm[k]) == (tbl_da[k] & tbl_dm[k]))
                   && in_span(b.src_ports, tbl_sr[k]) && in_span(b.dst_ports, tbl_dr[k])
                   && (tbl_pr[k] == 0 || tbl_pr[k] == b.protocol)) begin
                  r.matched = 1;
                  r.hit = 6'(k);
                  r.accept = tbl_acc[k];
                  r.log_flag = tbl_log[k];
                  break;
               end
            end
         end
         fmrc_pkg::CMD_WRITE: begin
            tbl_valid[b.index] = 1;
            tbl_sa[b.index] = b.src_addr;
            tbl_sm[b.index] = b.src_mask;
            tbl_da[b.index] = b.dst_addr;
            tbl_dm[b.index] = b.dst_mask;
            tbl_sr[b.index] = b.src_ports;
            tbl_dr[b.index] = b.dst_ports;
            tbl_pr[b.index] = b.protocol;
            tbl_acc[b.index] = b.accept;
            tbl_log[b.index] = b.log_flag;
         end
         fmrc_pkg::CMD_INVALIDATE: tbl_valid[b.index] = 0;
         default: begin
            for (int k = 0; k < RULES; k++) tbl_valid[k] = 0;
         end
      endcase
      return r;
   endfunction

   function automatic req_beat rand_beat(fmrc_pkg::cmd_type c);
      req_beat b;
      b.cmd = c;
      b.index = 6'($urandom_range(0, 63));
      b.src_addr = $urandom;
      b.src_mask = $urandom;
      b.dst_addr = $urandom;
      b.dst_mask = $urandom;
      b.src_ports = $urandom;
      b.dst_ports = $urandom;
      b.protocol = 8'($urandom);
      b.accept = 1'($urandom);
      b.log_flag = 1'($urandom);
      return b;
   endfunction

   // rule that a packet can hit: short masks and wide ranges
   function automatic req_beat rand_rule(logic [5:0] idx);
      req_beat b;
      int lo_s, lo_d;
      b = rand_beat(fmrc_pkg::CMD_WRITE);
      b.index = idx;
      b.src_mask = 32'hffff_ffff << $urandom_range(8, 32);
      b.dst_mask = 32'hffff_ffff << $urandom_range(8, 32);
      b.src_addr = {8'h0a, 24'($urandom)};
      b.dst_addr = {8'hc0, 24'($urandom)};
      lo_s = $urandom_range(0, 40000);
      lo_d = $urandom_range(0, 40000);
      b.src_ports = {16'(lo_s), 16'($urandom_range(lo_s, 65535))};
      b.dst_ports = {16'(lo_d), 16'($urandom_range(lo_d, 65535))};
      if ($urandom_range(0, 3) == 0) b.src_ports = {16'hffff, 16'h0000};
      b.protocol = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 17));
      return b;
   endfunction

   function automatic req_beat rand_packet();
      req_beat b;
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY);
      b.src_addr = {8'h0a, 24'($urandom)};
      b.dst_addr = {8'hc0, 24'($urandom)};
      b.protocol = 8'($urandom_range(0, 17));
      if ($urandom_range(0, 3) == 0) b = rand_beat(fmrc_pkg::CMD_CLASSIFY);
      return b;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic load_phase(int n);
      req_beat b;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) b = rand_rule(6'($urandom_range(0, 63)));
         else if (r < 36) b = rand_beat(fmrc_pkg::CMD_INVALIDATE);
         else if (r < 37) b = rand_beat(fmrc_pkg::CMD_CLEAR);
         else b = rand_packet();
         pending_reqs.push_back(b);
      end
   endtask

   initial begin
      req_beat b;
      foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
      reset = 1;
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 0;

      // directed: field extremes, all commands, empty range
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY); pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_WRITE);
      b.index = 63; b.src_mask = 0; b.dst_mask = 0; b.src_ports = 32'h0000_ffff;
      b.dst_ports = 32'h0000_ffff; b.protocol = 0; b.accept = 1; b.log_flag = 1;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY); b.src_ports = 32'hffff_ffff; b.dst_ports = 0;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_WRITE);
      b.index = 0; b.src_mask = '1; b.dst_mask = '1; b.src_addr = '1; b.dst_addr = 0;
      b.src_ports = 32'h0000_ffff; b.dst_ports = 32'h0000_ffff; b.protocol = 8'hff;
      b.accept = 0; b.log_flag = 0;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY);
      b.src_addr = '1; b.dst_addr = 0; b.protocol = 8'hff;
      pending_reqs.push_back(b);
      b.protocol = 8'hfe; pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_WRITE); b.index = 1; b.src_mask = 0; b.dst_mask = 0;
      b.src_ports = 32'h0010_000f; b.dst_ports = 32'h0000_ffff; b.protocol = 0;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY); b.src_ports = 32'h0000_0010;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_WRITE); b.index = 2; b.src_mask = 0; b.dst_mask = 0;
      b.src_ports = 32'h1234_1234; b.dst_ports = 32'hffff_ffff; b.protocol = 0;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY);
      b.src_ports = 32'h0000_1234; b.dst_ports = 32'hffff;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_INVALIDATE); b.index = 0; pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_CLASSIFY);
      b.src_addr = '1; b.dst_addr = 0; b.protocol = 8'hff;
      pending_reqs.push_back(b);
      b = rand_beat(fmrc_pkg::CMD_INVALIDATE); b.index = 63; pending_reqs.push_back(b);
      pending_reqs.push_back(rand_beat(fmrc_pkg::CMD_CLASSIFY));
      pending_reqs.push_back(rand_beat(fmrc_pkg::CMD_CLEAR));
      pending_reqs.push_back(rand_beat(fmrc_pkg::CMD_CLASSIFY));
      wait_drained();

      foreach (tb_pct[i]) begin
         send_idle_pct = tb_pct[i][0];
         recv_stall_pct = tb_pct[i][1];
         for (int k = 0; k < 16; k++) pending_reqs.push_back(rand_rule(6'(k * 4)));
         load_phase(200);
         if (i == 1) hold_off = 300;
         wait_drained();
      end
      gen_done = 1;
   end

   // hold the request when it was offered but not taken at this edge
   always @(posedge clock) begin
      req_held <= !reset && req_valid && req_stall;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         {req_cmd, req_index, req_src_addr, req_src_mask, req_dst_addr, req_dst_mask,
          req_src_ports, req_dst_ports, req_protocol, req_rule_accept, req_rule_log} <= '0;
      end else if (!req_held) begin
         if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            b_drv = pending_reqs.pop_front();
            expected_verdicts.push_back(lookup_verdict(b_drv));
            req_valid <= 1;
            req_cmd <= b_drv.cmd;
            req_index <= b_drv.index;
            req_src_addr <= b_drv.src_addr;
            req_src_mask <= b_drv.src_mask;
            req_dst_addr <= b_drv.dst_addr;
            req_dst_mask <= b_drv.dst_mask;
            req_src_ports <= b_drv.src_ports;
            req_dst_ports <= b_drv.dst_ports;
            req_protocol <= b_drv.protocol;
            req_rule_accept <= b_drv.accept;
            req_rule_log <= b_drv.log_flag;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 0;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      rsp_beat e;
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected response matched=%0b hit=%0d", $time, rsp_matched,
                     rsp_hit_index);
            fail_cnt++;
         end else begin
            e = expected_verdicts.pop_front();
            if (rsp_matched !== e.matched || rsp_hit_index !== e.hit
                || rsp_verdict_accept !== e.accept || rsp_verdict_log !== e.log_flag) begin
               $write("%0t: expected m=%0b hit=%0d acc=%0b log=%0b, ",
                      $time, e.matched, e.hit, e.accept, e.log_flag);
               $display("got m=%0b hit=%0d acc=%0b log=%0b", rsp_matched,
                        rsp_hit_index, rsp_verdict_accept, rsp_verdict_log);
               fail_cnt++;
            end
         end
      end
      if (cycle_cnt >= MAX_CYC) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      wait (gen_done);
      repeat (SETTLE) @(posedge clock);
      if (fail_cnt == 0 && expected_verdicts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### first_match_packet_rule_classifier.f
rtl/fmrc_pkg.sv
rtl/fmrc_cell.sv
rtl/first_match_packet_rule_classifier.sv
tb/sv/tb_top.sv
